### rtl/tlrbq_pkg.sv
// shared types, sizes and helpers for the three-level ready/blocked queue scheduler
// no dependencies; imported by every module of the block except tlrbq_ram

package tlrbq_pkg;

	localparam int LEVELS      = 3;
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 8;

	// ready queues of all levels first, then the blocked queues
	localparam int NQ        = 2 * LEVELS;
	localparam int MEM_DEPTH = NQ * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int QI_W      = $clog2(NQ);
	localparam int LV_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	typedef logic [ID_WIDTH-1:0] id_t;
	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [QI_W-1:0]     qidx_t;
	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [LV_W-1:0]     lvl_t;

	typedef enum logic [2:0] {
		K_ADD_R    = 3'd0,
		K_DROP_R   = 3'd1,
		K_ADD_B    = 3'd2,
		K_POP_B    = 3'd3,
		K_CLEAR    = 3'd4,
		K_PREEMPT  = 3'd5,
		K_DISPATCH = 3'd6,
		K_NOP      = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_BADLVL = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// request from the sequencer to the pointer tables
	typedef struct packed {
		logic  look;
		qidx_t q;
		logic  push;
		logic  pop;
	} qp_req_t;

	// pointer table answers: snapshot flags and memory addresses
	typedef struct packed {
		logic  full;
		logic  empty;
		addr_t rd_addr;
		addr_t wr_addr;
	} qp_rsp_t;

	function automatic addr_t qaddr(qidx_t q, ptr_t p);
		return ADDR_W'(int'(q) * QUEUE_DEPTH + int'(p));
	endfunction

	function automatic ptr_t ptr_inc(ptr_t p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

### rtl/tlrbq_ram.sv
// generic single-clock ram: one write port, one read port with registered data
// no package dependencies

module tlrbq_ram #(
	parameter int DEPTH = 96,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/tlrbq_qptr.sv
// head, tail and count tables for every ready and blocked queue
// depends on tlrbq_pkg; takes a snapshot of one queue per command

module tlrbq_qptr import tlrbq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  qp_req_t req,
	output qp_rsp_t rsp
);

	ptr_t  head_q [NQ];
	ptr_t  tail_q [NQ];
	cnt_t  cnt_q  [NQ];

	qidx_t q_s1;
	ptr_t  head_s1;
	ptr_t  tail_s1;
	cnt_t  cnt_s1;

	ptr_t  head_rd;
	ptr_t  tail_rd;
	cnt_t  cnt_rd;

	// one read of each table per cycle, at the queue of the beat being accepted
	assign head_rd = head_q[req.q];
	assign tail_rd = tail_q[req.q];
	assign cnt_rd  = cnt_q[req.q];

	always_ff @(posedge clk) begin
		if (req.look) begin
			q_s1    <= req.q;
			head_s1 <= head_rd;
			tail_s1 <= tail_rd;
			cnt_s1  <= cnt_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NQ; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (req.push) begin
				tail_q[q_s1] <= ptr_inc(tail_s1);
				cnt_q[q_s1]  <= cnt_s1 + 1'b1;
			end else if (req.pop) begin
				head_q[q_s1] <= ptr_inc(head_s1);
				cnt_q[q_s1]  <= cnt_s1 - 1'b1;
			end
		end
	end

	assign rsp.rd_addr = qaddr(req.q, head_rd);
	assign rsp.wr_addr = qaddr(q_s1, tail_s1);
	assign rsp.full    = (cnt_s1 == CNT_W'(QUEUE_DEPTH));
	assign rsp.empty   = (cnt_s1 == '0);

endmodule

### rtl/three_level_ready_block_queues.sv
// top level of the three-level ready/blocked queue scheduler
// depends on tlrbq_pkg, tlrbq_ram and tlrbq_qptr
//
//  channel  handshake          fields
//  in       in_valid/in_stall  kind, level, proc_id, to_ready
//  out      out_valid/out_stall running_id, running_valid, status
//
// each command has two steps: accept (queue pointer snapshot and ram read of
// the ready head) then execute (memory write, pointer and running slot update)
// the registered read data of the queue ram sets this; one command is in flight at a time
// reset clears all pointers, counts and running slots; the ram needs no clearing
// a result waiting on out_stall holds the command in execute; in_stall stays high

module three_level_ready_block_queues import tlrbq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] kind,
	input  logic [1:0] level,
	input  logic [7:0] proc_id,
	input  logic       to_ready,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] running_id,
	output logic       running_valid,
	output logic [1:0] status
);

	state_t  state_q, state_nx;
	logic    acc, commit;

	kind_t   kind_q;
	logic [1:0] lv_q;
	id_t     id_q;

	qp_req_t qreq;
	qp_rsp_t qrsp;
	id_t     rd_data;

	id_t     run_id_q [LEVELS];
	logic    run_v_q  [LEVELS];
	id_t     run_id_nx [LEVELS];
	logic    run_v_nx  [LEVELS];

	logic    out_valid_q;
	id_t     out_id_q;
	logic    out_rv_q;
	status_t out_stat_q;

	kind_t   kind_in;
	logic    lv_in_ok, blk_in, lv_ok;
	lvl_t    lvi_in, lvi;
	status_t stat;
	logic    do_push, do_pop, run_clr, run_set;
	id_t     sel_id;
	logic    sel_v;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_EXEC;
			end
			S_EXEC: begin
				if (!out_valid_q || !out_stall) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		in_stall = 1'b1;
		commit   = 1'b0;
		case (state_q)
			S_IDLE: in_stall = 1'b0;
			S_EXEC: commit = !out_valid_q || !out_stall;
			default: in_stall = 1'b1;
		endcase
	end

	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q <= kind_t'(kind);
			lv_q   <= level;
			id_q   <= ID_WIDTH'(proc_id);
		end
	end

	// pick the queue of the incoming beat so the snapshot is ready for execute
	always_comb begin
		kind_in  = kind_t'(kind);
		lv_in_ok = int'(level) < LEVELS;
		lvi_in   = lv_in_ok ? LV_W'(level) : '0;
		blk_in   = (kind_in == K_ADD_B) || (kind_in == K_POP_B) ||
		           ((kind_in == K_PREEMPT) && !to_ready);
		qreq.look = acc;
		qreq.q    = blk_in ? QI_W'(int'(lvi_in) + LEVELS) : QI_W'(lvi_in);
		qreq.push = commit && do_push;
		qreq.pop  = commit && do_pop;
	end

	tlrbq_qptr u_qptr (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (qreq),
		.rsp    (qrsp)
	);

	// writes happen only in execute and reads only at accept, so they never overlap
	tlrbq_ram #(
		.DEPTH (MEM_DEPTH),
		.WIDTH (ID_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (commit && do_push),
		.wr_addr (qrsp.wr_addr),
		.wr_data (id_q),
		.rd_en   (acc),
		.rd_addr (qrsp.rd_addr),
		.rd_data (rd_data)
	);

	// command decode in execute
	always_comb begin
		lv_ok   = int'(lv_q) < LEVELS;
		lvi     = lv_ok ? LV_W'(lv_q) : '0;
		stat    = STAT_OK;
		do_push = 1'b0;
		do_pop  = 1'b0;
		run_clr = 1'b0;
		run_set = 1'b0;
		if (kind_q != K_NOP) begin
			if (!lv_ok) begin
				stat = STAT_BADLVL;
			end else begin
				case (kind_q)
					K_ADD_R, K_ADD_B: begin
						if (qrsp.full) stat = STAT_FULL;
						else do_push = 1'b1;
					end
					K_DROP_R, K_POP_B: begin
						if (qrsp.empty) stat = STAT_EMPTY;
						else do_pop = 1'b1;
					end
					K_CLEAR: run_clr = 1'b1;
					K_PREEMPT: begin
						if (qrsp.full) begin
							stat = STAT_FULL;
						end else begin
							do_push = 1'b1;
							run_clr = 1'b1;
						end
					end
					K_DISPATCH: begin
						if (qrsp.empty) begin
							stat = STAT_EMPTY;
						end else begin
							do_pop  = 1'b1;
							run_set = 1'b1;
						end
					end
					default: stat = STAT_OK;
				endcase
			end
		end
	end

	// running slots after this command, then highest valid level wins
	always_comb begin
		sel_id = '0;
		sel_v  = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			run_id_nx[i] = run_id_q[i];
			run_v_nx[i]  = run_v_q[i];
			if (lvi == LV_W'(i)) begin
				if (run_clr) begin
					run_id_nx[i] = '0;
					run_v_nx[i]  = 1'b0;
				end else if (run_set) begin
					run_id_nx[i] = rd_data;
					run_v_nx[i]  = 1'b1;
				end
			end
			if (run_v_nx[i]) begin
				sel_id = run_id_nx[i];
				sel_v  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				run_id_q[i] <= '0;
				run_v_q[i]  <= 1'b0;
			end
		end else if (commit) begin
			for (int i = 0; i < LEVELS; i++) begin
				run_id_q[i] <= run_id_nx[i];
				run_v_q[i]  <= run_v_nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_id_q   <= sel_id;
			out_rv_q   <= sel_v;
			out_stat_q <= stat;
		end
	end

	assign out_valid     = out_valid_q;
	assign running_id    = 8'(out_id_q);
	assign running_valid = out_rv_q;
	assign status        = out_stat_q;

	a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc && commit))
		else $error("beat accepted while a command executes");

	a_idle_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (running_valid || running_id == 8'd0))
		else $error("running_id nonzero with no running process");

	a_full_only_push: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && stat == STAT_FULL) |->
		(kind_q == K_ADD_R || kind_q == K_ADD_B || kind_q == K_PREEMPT))
		else $error("full status on a command that does not push");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(commit))
		else $error("result appeared without an executed command");

endmodule
